>>> sv/tsu_pkg.sv
// Package for the timestamp uniquifier: payload structs, cell control struct,
// status codes and fixed widths. No dependencies.
package tsu_pkg;

  localparam int TsW  = 64;  // timestamp width
  localparam int CntW = 9;   // adjustment counter width
  localparam int MaxW = 8;   // max_adjustments register width

  localparam logic [MaxW-1:0] MaxAdjRst = 8'd32;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusLimit = 1'b1;

  typedef struct packed {
    logic           new_track;
    logic [TsW-1:0] pts_in;
    logic [TsW-1:0] dts_in;
  } tsu_in_t;

  typedef struct packed {
    logic [TsW-1:0] pts_out;
    logic [TsW-1:0] dts_out;
    logic           status;
  } tsu_out_t;

  // Control broadcast to every window cell.
  typedef struct packed {
    logic clear;  // drop all entries (new track)
    logic shift;  // take neighbor's entry, chain moves toward cell 0
  } tsu_cell_ctrl_t;

endpackage

>>> sv/tsu_cell.sv
// One window cell: holds one presentation and one decode timestamp with a valid bit.
// Depends on tsu_pkg.
module tsu_cell
  import tsu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsu_cell_ctrl_t ctrl_i,
  input  logic [TsW-1:0] pts_i,
  input  logic [TsW-1:0] dts_i,
  input  logic           valid_i,
  input  logic [TsW-1:0] cand_pts_i,
  input  logic [TsW-1:0] cand_dts_i,
  output logic [TsW-1:0] pts_o,
  output logic [TsW-1:0] dts_o,
  output logic           valid_o,
  output logic           match_o
);

  logic [TsW-1:0] pts_q, dts_q;
  logic           valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      pts_q <= pts_i;
      dts_q <= dts_i;
    end
  end

  assign pts_o   = pts_q;
  assign dts_o   = dts_q;
  assign valid_o = valid_q;
  assign match_o = valid_q & ((pts_q == cand_pts_i) | (dts_q == cand_dts_i));

endmodule

>>> sv/tsu_xchg.sv
// Eviction exchange at the chain head: keeps the running minimum of each window
// while the ring rotates, and feeds the rest back to the tail. Depends on tsu_pkg.
module tsu_xchg
  import tsu_pkg::*;
(
  input  logic           clk_i,
  input  logic           step_i,   // one ring rotation step
  input  logic           first_i,  // first step: new value replaces head
  input  logic [TsW-1:0] head_pts_i,
  input  logic [TsW-1:0] head_dts_i,
  input  logic [TsW-1:0] new_pts_i,
  input  logic [TsW-1:0] new_dts_i,
  output logic [TsW-1:0] tail_pts_o,
  output logic [TsW-1:0] tail_dts_o
);

  logic [TsW-1:0] carry_pts_q, carry_pts_d;
  logic [TsW-1:0] carry_dts_q, carry_dts_d;
  logic           pts_lt, dts_lt;

  assign pts_lt = head_pts_i < carry_pts_q;
  assign dts_lt = head_dts_i < carry_dts_q;

  // Window values are distinct, so the smaller one is always well defined.
  always_comb begin
    if (first_i) begin
      tail_pts_o  = new_pts_i;
      tail_dts_o  = new_dts_i;
      carry_pts_d = head_pts_i;
      carry_dts_d = head_dts_i;
    end else begin
      tail_pts_o  = pts_lt ? carry_pts_q : head_pts_i;
      tail_dts_o  = dts_lt ? carry_dts_q : head_dts_i;
      carry_pts_d = pts_lt ? head_pts_i : carry_pts_q;
      carry_dts_d = dts_lt ? head_dts_i : carry_dts_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      carry_pts_q <= carry_pts_d;
      carry_dts_q <= carry_dts_d;
    end
  end

endmodule

>>> sv/timestamp_uniquifier_core.sv
// Timestamp uniquifier top level: control FSM, adjustment counter, config register,
// the chain of window cells and the eviction exchange. Depends on tsu_pkg, tsu_cell, tsu_xchg.
//
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_data_i (new_track, pts_in, dts_in).
//   out channel : out_valid_o / out_stall_i / out_data_o (pts_out, dts_out, status).
//   cfg channel : cfg_valid_i / cfg_ready_o / cfg_data_i writes max_adjustments;
//                 always ready, write only while the block is idle.
//   A transaction moves when valid is high and stall is low (ready high for cfg).
// Operation:
//   One transaction at a time: accept, then one window lookup; when the output
//   is free, the result is in the output register on the edge that ends the lookup.
//   Each collision costs one extra lookup (timestamps + 1, counter + 1).
//   Inserting into a full window rotates the cell ring once through the single
//   compare-exchange at the chain head.
//   Not-full insertion is a shift into the chain tail during the lookup.
// Reset clears all valid bits, the counter, the error flag and the output valid;
// the limit goes back to 32. No clearing pass is needed.
// A stalled output holds its transaction; the block keeps working on the next
// transaction and waits in a hold state only when a second result is ready.
module timestamp_uniquifier_core
  import tsu_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tsu_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tsu_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [MaxW-1:0] cfg_data_i
);

  localparam int StepW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [StepW-1:0] StepLast = StepW'(WINDOW - 1);

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StEvict,
    StEmit
  } state_e;

  state_e          state_q, state_d;
  logic [TsW-1:0]  cand_pts_q, cand_pts_d, cand_dts_q, cand_dts_d;
  logic [TsW-1:0]  orig_pts_q, orig_pts_d, orig_dts_q, orig_dts_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;
  logic [MaxW-1:0] max_q, max_d;
  logic [StepW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;
  tsu_out_t        out_q, out_d;
  tsu_out_t        res_q, res_d, res_n;

  logic            accept, out_free, hit, full, finish;
  tsu_cell_ctrl_t  cell_ctrl;
  logic            xchg_step, xchg_first;
  logic [TsW-1:0]  xchg_pts, xchg_dts;

  // Chain: entry i+1 feeds cell i; entry WINDOW is the tail, entry 0 the head.
  logic [TsW-1:0]  chain_pts [WINDOW+1];
  logic [TsW-1:0]  chain_dts [WINDOW+1];
  logic            chain_vld [WINDOW+1];
  logic [WINDOW-1:0] match;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign hit         = |match;
  assign full        = chain_vld[0];  // entries fill from the tail, so head valid == full

  // Tail input: new candidate on a plain push, exchange output while rotating.
  assign chain_pts[WINDOW] = (state_q == StEvict) ? xchg_pts : cand_pts_q;
  assign chain_dts[WINDOW] = (state_q == StEvict) ? xchg_dts : cand_dts_q;
  assign chain_vld[WINDOW] = 1'b1;

  always_comb begin
    state_d     = state_q;
    cand_pts_d  = cand_pts_q;
    cand_dts_d  = cand_dts_q;
    orig_pts_d  = orig_pts_q;
    orig_dts_d  = orig_dts_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    max_d       = max_q;
    step_d      = step_q;
    res_d       = res_q;
    res_n       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    cell_ctrl   = '0;
    xchg_step   = 1'b0;
    xchg_first  = 1'b0;
    finish      = 1'b0;

    if (cfg_valid_i) begin
      max_d = cfg_data_i;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          cand_pts_d = in_data_i.pts_in;
          cand_dts_d = in_data_i.dts_in;
          orig_pts_d = in_data_i.pts_in;
          orig_dts_d = in_data_i.dts_in;
          if (in_data_i.new_track) begin
            cnt_d           = '0;
            err_d           = 1'b0;
            cell_ctrl.clear = 1'b1;
          end
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (err_q) begin
          // sticky error: pass through untouched
          finish = 1'b1;
          res_n  = '{pts_out: orig_pts_q, dts_out: orig_dts_q, status: StatusLimit};
        end else if (hit) begin
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q >= {1'b0, max_q}) begin
            // limit passed: give up on this track, windows unchanged
            err_d  = 1'b1;
            finish = 1'b1;
            res_n  = '{pts_out: orig_pts_q, dts_out: orig_dts_q, status: StatusLimit};
          end else begin
            cand_pts_d = cand_pts_q + TsW'(1);
            cand_dts_d = cand_dts_q + TsW'(1);
          end
        end else if (!full) begin
          cell_ctrl.shift = 1'b1;
          finish          = 1'b1;
          res_n = '{pts_out: cand_pts_q, dts_out: cand_dts_q, status: StatusOk};
        end else begin
          step_d  = '0;
          state_d = StEvict;
        end
      end
      StEvict: begin
        cell_ctrl.shift = 1'b1;
        xchg_step       = 1'b1;
        xchg_first      = (step_q == '0);
        if (step_q == StepLast) begin
          finish = 1'b1;
          res_n  = '{pts_out: cand_pts_q, dts_out: cand_dts_q, status: StatusOk};
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StEmit: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        out_d       = res_n;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end else begin
        res_d   = res_n;
        state_d = StEmit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      max_q       <= MaxAdjRst;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      max_q       <= max_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_pts_q <= cand_pts_d;
    cand_dts_q <= cand_dts_d;
    orig_pts_q <= orig_pts_d;
    orig_dts_q <= orig_dts_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tsu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .pts_i      (chain_pts[i+1]),
      .dts_i      (chain_dts[i+1]),
      .valid_i    (chain_vld[i+1]),
      .cand_pts_i (cand_pts_q),
      .cand_dts_i (cand_dts_q),
      .pts_o      (chain_pts[i]),
      .dts_o      (chain_dts[i]),
      .valid_o    (chain_vld[i]),
      .match_o    (match[i])
    );
  end

  tsu_xchg u_xchg (
    .clk_i      (clk_i),
    .step_i     (xchg_step),
    .first_i    (xchg_first),
    .head_pts_i (chain_pts[0]),
    .head_dts_i (chain_dts[0]),
    .new_pts_i  (cand_pts_q),
    .new_dts_i  (cand_dts_q),
    .tail_pts_o (xchg_pts),
    .tail_dts_o (xchg_dts)
  );

endmodule

>>> sv/tsu_checker.sv
// Port-level checks for timestamp_uniquifier_core, attached by bind.
// Depends on tsu_pkg.
module tsu_port_checks
  import tsu_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input tsu_out_t out_data_o
);

  // Stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // Stalled result does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Block is busy in the cycle after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous transaction in flight");

  // A new result only appears at the end of a busy cycle.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind timestamp_uniquifier_core tsu_port_checks u_tsu_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
